// ===== hw/rtl/ofct_pkg.sv =====
// shared types, codes and limits for the overlap framing corner turn
`default_nettype none

package ofct_pkg;

    localparam int MAX_WORDS_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BINS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POL_PAIRS     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LENGTH  = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [12:0] frame_bins;
        logic [10:0] overlap;
        logic [8:0]  frame_count;
        logic [8:0]  channel_count;
        logic [1:0]  pol_pairs;
        logic [16:0] chunk_length;
        logic [12:0] nb;
        logic [8:0]  nf;
        logic [8:0]  nc;
        logic [1:0]  np;
        logic [13:0] hop;
    } cfg_t;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic out_free;
    } ctrl_stat_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic addr;
        logic out_load;
    } ctrl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ofct_regs.sv =====
// configuration register file with bounded sizes and frame hop
`default_nettype none

module ofct_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ofct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ofct_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ofct_pkg::cfg_t                          cfg
);
    import ofct_pkg::*;

    logic [12:0] frame_bins_reg, frame_bins_next;
    logic [10:0] overlap_reg, overlap_next;
    logic [8:0]  frame_count_reg, frame_count_next;
    logic [8:0]  channel_count_reg, channel_count_next;
    logic [1:0]  pol_pairs_reg, pol_pairs_next;
    logic [16:0] chunk_length_reg, chunk_length_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        frame_bins_next    = frame_bins_reg;
        overlap_next       = overlap_reg;
        frame_count_next   = frame_count_reg;
        channel_count_next = channel_count_reg;
        pol_pairs_next     = pol_pairs_reg;
        chunk_length_next  = chunk_length_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_BINS:    frame_bins_next    = cfg_data[12:0];
                REG_OVERLAP:       overlap_next       = cfg_data[10:0];
                REG_FRAME_COUNT:   frame_count_next   = cfg_data[8:0];
                REG_CHANNEL_COUNT: channel_count_next = cfg_data[8:0];
                REG_POL_PAIRS:     pol_pairs_next     = cfg_data[1:0];
                REG_CHUNK_LENGTH:  chunk_length_next  = cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bins_reg    <= 13'd8;
            overlap_reg       <= 11'd0;
            frame_count_reg   <= 9'd1;
            channel_count_reg <= 9'd1;
            pol_pairs_reg     <= 2'd2;
            chunk_length_reg  <= 17'd8;
        end else begin
            frame_bins_reg    <= frame_bins_next;
            overlap_reg       <= overlap_next;
            frame_count_reg   <= frame_count_next;
            channel_count_reg <= channel_count_next;
            pol_pairs_reg     <= pol_pairs_next;
            chunk_length_reg  <= chunk_length_next;
        end
    end

    always_comb begin
        cfg.frame_bins    = frame_bins_reg;
        cfg.overlap       = overlap_reg;
        cfg.frame_count   = frame_count_reg;
        cfg.channel_count = channel_count_reg;
        cfg.pol_pairs     = pol_pairs_reg;
        cfg.chunk_length  = chunk_length_reg;
        // zero counts as one, large values saturate
        if (frame_bins_reg == 13'd0) cfg.nb = 13'd1;
        else if (frame_bins_reg > 13'd4096) cfg.nb = 13'd4096;
        else cfg.nb = frame_bins_reg;
        if (frame_count_reg == 9'd0) cfg.nf = 9'd1;
        else if (frame_count_reg > 9'd256) cfg.nf = 9'd256;
        else cfg.nf = frame_count_reg;
        if (channel_count_reg == 9'd0) cfg.nc = 9'd1;
        else if (channel_count_reg > 9'd256) cfg.nc = 9'd256;
        else cfg.nc = channel_count_reg;
        if (pol_pairs_reg == 2'd0) cfg.np = 2'd1;
        else if (pol_pairs_reg > 2'd2) cfg.np = 2'd2;
        else cfg.np = pol_pairs_reg;
        cfg.hop = {1'b0, frame_bins_reg} - {2'b00, overlap_reg, 1'b0};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ofct_ctrl.sv =====
// sequencing state machine for loads and reads
`default_nettype none

module ofct_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ofct_pkg::ctrl_stat_t stat,
    output ofct_pkg::ctrl_cmd_t       cmd,
    output logic                      s_tready
);
    import ofct_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.in_valid && stat.in_op == OP_READ) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_OUT;
            ST_OUT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = stat.in_valid && stat.in_op == OP_LOAD;
            end
            ST_MUL:  cmd.mul  = 1'b1;
            ST_ADDR: cmd.addr = 1'b1;
            ST_OUT:  cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ofct_dp.sv =====
// sample store, frame counters, address arithmetic and output register
`default_nettype none

module ofct_dp #(
    parameter int MAX_WORDS   = ofct_pkg::MAX_WORDS_DEF,
    parameter int SAMPLE_BITS = ofct_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ofct_pkg::cfg_t      cfg,
    input  wire ofct_pkg::ctrl_cmd_t cmd,
    output logic                     out_free,
    input  wire logic [31:0]         s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);
    import ofct_pkg::*;

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PW = $clog2(MAX_WORDS + 1);
    localparam int SB = SAMPLE_BITS;

    logic [2*SB-1:0] store_mem [MAX_WORDS];
    logic [2*SB-1:0] rd_data_reg;

    logic [PW-1:0] ptr_reg, ptr_next;
    logic          ovf_reg, ovf_next;
    logic [11:0]   bin_reg, bin_next;
    logic [7:0]    chan_reg, chan_next;
    logic [7:0]    frame_reg, frame_next;
    logic          pol_reg, pol_next;

    logic signed [22:0] prod_f_reg, prod_f_next;
    logic [24:0]        prod_c_reg, prod_c_next;
    logic signed [23:0] prod_m_reg, prod_m_next;

    logic       zero_reg, zero_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    logic              load_ok;
    logic signed [SB-1:0] wr_re, wr_im, rd_re, rd_im;
    logic              mismatch, in_range, w_ok, rd_en;
    logic signed [23:0] s_idx;
    logic [25:0]       base;
    logic [26:0]       w_addr;
    logic              bin_end, ch_end, fr_end, pol_end, last;

    assign load_ok = ptr_reg < PW'(MAX_WORDS);
    assign wr_re   = SB'($signed(s_tdata[15:0]));
    assign wr_im   = SB'($signed(s_tdata[31:16]));

    // address stage
    always_comb begin
        prod_f_next = $signed(cfg.hop) * $signed({1'b0, frame_reg});
        prod_c_next = chan_reg * cfg.chunk_length;
        prod_m_next = $signed(cfg.hop) * $signed({1'b0, cfg.frame_count});

        mismatch = prod_m_reg != $signed({7'd0, cfg.chunk_length});
        s_idx    = $signed({12'd0, bin_reg}) - $signed({13'd0, cfg.overlap})
                 + 24'(prod_f_reg);
        in_range = !s_idx[23] && (s_idx[22:0] < {6'd0, cfg.chunk_length});
        base     = {1'b0, prod_c_reg} + {9'd0, s_idx[16:0]};
        w_addr   = ((cfg.np == 2'd2) ? {base, 1'b0} : {1'b0, base}) + {26'd0, pol_reg};
        w_ok     = w_addr < 27'(MAX_WORDS);
        rd_en    = cmd.addr && !mismatch && in_range && w_ok;

        zero_next   = zero_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (cmd.addr) begin
            zero_next = mismatch || !in_range || !w_ok;
            if (mismatch) status_next = STATUS_MISMATCH;
            else if (ovf_reg) status_next = STATUS_OVERFLOW;
            else status_next = STATUS_OK;
            last_next = last;
        end
    end

    // counter advance and load pointer
    always_comb begin
        bin_end = ({1'b0, bin_reg} + 13'd1) >= cfg.nb;
        ch_end  = ({1'b0, chan_reg} + 9'd1) >= cfg.nc;
        fr_end  = ({1'b0, frame_reg} + 9'd1) >= cfg.nf;
        pol_end = ({1'b0, pol_reg} + 2'd1) >= cfg.np;
        last    = bin_end && ch_end && fr_end && pol_end;

        ptr_next   = ptr_reg;
        ovf_next   = ovf_reg;
        bin_next   = bin_reg;
        chan_next  = chan_reg;
        frame_next = frame_reg;
        pol_next   = pol_reg;

        if (cmd.load) begin
            if (load_ok) ptr_next = ptr_reg + PW'(1);
            else ovf_next = 1'b1;
        end

        if (cmd.addr) begin
            priority if (last) begin
                ptr_next   = '0;
                ovf_next   = 1'b0;
                bin_next   = '0;
                chan_next  = '0;
                frame_next = '0;
                pol_next   = 1'b0;
            end else if (!bin_end) begin
                bin_next = bin_reg + 12'd1;
            end else begin
                bin_next = '0;
                priority if (!ch_end) begin
                    chan_next = chan_reg + 8'd1;
                end else begin
                    chan_next = '0;
                    priority if (!fr_end) begin
                        frame_next = frame_reg + 8'd1;
                    end else begin
                        frame_next = '0;
                        pol_next   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            ovf_reg   <= 1'b0;
            bin_reg   <= '0;
            chan_reg  <= '0;
            frame_reg <= '0;
            pol_reg   <= 1'b0;
        end else begin
            ptr_reg   <= ptr_next;
            ovf_reg   <= ovf_next;
            bin_reg   <= bin_next;
            chan_reg  <= chan_next;
            frame_reg <= frame_next;
            pol_reg   <= pol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_f_reg <= prod_f_next;
            prod_c_reg <= prod_c_next;
            prod_m_reg <= prod_m_next;
        end
        zero_reg   <= zero_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            store_mem[ptr_reg[AW-1:0]] <= {wr_im, wr_re};
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[w_addr[AW-1:0]];
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_tready;
    assign rd_re    = rd_data_reg[SB-1:0];
    assign rd_im    = rd_data_reg[2*SB-1:SB];

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = zero_reg ? 32'd0 : {16'(rd_im), 16'(rd_re)};
            m_user_next  = status_reg;
            m_last_next  = last_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/overlap_frame_corner_turn.sv =====
// top level of the overlap framing corner turn
// Input words on the s_ channel: s_tuser is the op (0 load, 1 read), s_tdata
// carries one complex sample. A load word writes the sample to the next free
// store word and is taken one per cycle while no read is in progress. A read
// word produces one output word on the m_ channel in polarisation, frame,
// channel, bin order. A read passes a multiply stage, an address stage with
// the registered store read and an output stage that loads the output
// register; the next input word is taken once it has returned to idle.
// m_tuser carries the status, m_tlast marks the final word of the chunk, after
// which the counters, load pointer and overflow flag clear.
// When the receiver stalls the output register holds its word; loads are still
// taken, and the next read waits in its last stage until the register frees.
// Configuration writes on the cfg_ channel are always ready and must be made
// while idle. Reset (aresetn low, synchronous) restores the register defaults
// and clears counters; the store contents are not cleared and need no sweep.
`default_nettype none

module overlap_frame_corner_turn #(
    parameter int MAX_WORDS   = ofct_pkg::MAX_WORDS_DEF,
    parameter int SAMPLE_BITS = ofct_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,   // sample_re, sample_im
    input  wire logic                             s_tuser,   // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [31:0]                           m_tdata,   // out_re, out_im
    output logic [1:0]                            m_tuser,   // status
    output logic                                  m_tlast,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ofct_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ofct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ofct_pkg::*;

    cfg_t       cfg;
    ctrl_stat_t stat;
    ctrl_cmd_t  cmd;
    logic       out_free;

    assign stat.in_valid = s_tvalid;
    assign stat.in_op    = s_tuser;
    assign stat.out_free = out_free;

    ofct_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ofct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    ofct_dp #(
        .MAX_WORDS   (MAX_WORDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .out_free (out_free),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ofct_checker.sv =====
// port level assertions for the overlap framing corner turn, with bind
`default_nettype none

module ofct_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import ofct_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word present after reset");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_READ |=> !s_tready)
        else $error("input taken while a read is in progress");

    a_mismatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_MISMATCH |-> m_tdata == 32'd0)
        else $error("length mismatch word carries data");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind overlap_frame_corner_turn ofct_checker u_checker (.*);

`default_nettype wire
